/* rtl/lcdfs_pkg.sv */
// shared types and constants of the lcd frame serializer
`timescale 1ns / 1ps

package lcdfs_pkg;

    // fixed widths of the request fields
    localparam int CMD_W   = 8;
    localparam int ADDR_W  = 6;
    localparam int NIB_W   = 4;

    // command payload length on the wire, command byte plus trailing zero
    localparam int CMD_BITS = 9;

    // frame id bits
    localparam int ID_BITS = 3;
    localparam logic [ID_BITS-1:0] ID_COMMAND = 3'b100;
    localparam logic [ID_BITS-1:0] ID_WRITE   = 3'b101;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // request kinds
    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_WRITE   = 1'b1
    } t_op;

    // per-frame flags travelling with a queued bit run
    typedef struct packed {
        logic frame_start;
        logic frame_end;
    } t_frame_ctl;

endpackage

/* rtl/lcdfs_front.sv */
// front end: classifies requests, tracks the open frame and builds bit runs
`timescale 1ns / 1ps

module lcdfs_front
    import lcdfs_pkg::*;
#(
    parameter int ADDRESS_BITS = 6,
    parameter int DATA_BITS    = 4,
    parameter int FRAME_BITS   = 13,
    parameter int LEN_W        = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_accept,
    input  t_op                   i_op,
    input  logic [CMD_W-1:0]      i_command_byte,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [NIB_W-1:0]      i_nibble,
    input  logic                  i_first_nibble,
    input  logic                  i_last_nibble,
    output logic                  o_valid,
    output logic [FRAME_BITS-1:0] o_bits,
    output logic [LEN_W-1:0]      o_len,
    output t_frame_ctl            o_ctl
);

    localparam int AEXT_W   = (ADDRESS_BITS > ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int DEXT_W   = (DATA_BITS > NIB_W) ? DATA_BITS : NIB_W;
    localparam int CMD_PAD  = CMD_BITS - CMD_W;
    localparam int CMD_LEN  = ID_BITS + CMD_BITS;
    localparam int HDR_LEN  = ID_BITS + ADDRESS_BITS + DATA_BITS;

    logic                  r_frame_open;
    logic                  n_frame_open;
    logic                  w_header;
    logic [AEXT_W-1:0]     w_addr_ext;
    logic [DEXT_W-1:0]     w_nib_ext;
    logic [CMD_BITS-1:0]   w_cmd_ext;

    assign w_addr_ext = AEXT_W'(i_address);
    assign w_nib_ext  = DEXT_W'(i_nibble);
    assign w_cmd_ext  = {i_command_byte, CMD_PAD'(0)};

    // a write opens a frame when asked to, or when none is open
    assign w_header = i_first_nibble || !r_frame_open;
    assign o_valid  = i_valid;

    // bit 0 of the run goes on the wire first
    always_comb begin
        o_bits = '0;
        o_len  = '0;
        o_ctl  = '0;
        if (i_op == OP_COMMAND) begin
            for (int k = 0; k < ID_BITS; k++) begin
                o_bits[k] = ID_COMMAND[ID_BITS-1-k];
            end
            for (int k = 0; k < CMD_BITS; k++) begin
                o_bits[ID_BITS+k] = w_cmd_ext[CMD_BITS-1-k];
            end
            o_len             = LEN_W'(CMD_LEN);
            o_ctl.frame_start = 1'b1;
            o_ctl.frame_end   = 1'b1;
        end else if (w_header) begin
            for (int k = 0; k < ID_BITS; k++) begin
                o_bits[k] = ID_WRITE[ID_BITS-1-k];
            end
            for (int k = 0; k < ADDRESS_BITS; k++) begin
                o_bits[ID_BITS+k] = w_addr_ext[ADDRESS_BITS-1-k];
            end
            for (int k = 0; k < DATA_BITS; k++) begin
                o_bits[ID_BITS+ADDRESS_BITS+k] = w_nib_ext[k];
            end
            o_len             = LEN_W'(HDR_LEN);
            o_ctl.frame_start = 1'b1;
            o_ctl.frame_end   = i_last_nibble;
        end else begin
            for (int k = 0; k < DATA_BITS; k++) begin
                o_bits[k] = w_nib_ext[k];
            end
            o_len             = LEN_W'(DATA_BITS);
            o_ctl.frame_start = 1'b0;
            o_ctl.frame_end   = i_last_nibble;
        end
    end

    always_comb begin
        n_frame_open = r_frame_open;
        if (i_accept) begin
            n_frame_open = (i_op == OP_WRITE) && !i_last_nibble;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
        end else begin
            r_frame_open <= n_frame_open;
        end
    end

endmodule

/* rtl/lcdfs_queue.sv */
// two-entry queue between front and back end
`timescale 1ns / 1ps

module lcdfs_queue #(
    parameter int WIDTH = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/lcdfs_back.sv */
// back end: shifts queued bit runs onto the wire through an output register
`timescale 1ns / 1ps

module lcdfs_back
    import lcdfs_pkg::*;
#(
    parameter int FRAME_BITS = 13,
    parameter int LEN_W      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [FRAME_BITS-1:0] i_q_bits,
    input  logic [LEN_W-1:0]      i_q_len,
    input  t_frame_ctl            i_q_ctl,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_data_bit,
    output t_frame_ctl            o_ctl,
    output logic                  o_last
);

    logic                  r_busy;
    logic [FRAME_BITS-1:0] r_shift;
    logic [LEN_W-1:0]      r_rem;
    logic                  r_fe;
    logic                  r_out_valid;
    logic                  r_out_bit;
    t_frame_ctl            r_out_ctl;
    logic                  r_out_last;

    logic                  w_advance;
    logic                  w_emit;
    logic [FRAME_BITS-1:0] w_src_bits;
    logic [LEN_W-1:0]      w_src_rem;
    logic                  w_src_fe;
    logic                  w_src_final;

    // the current run continues, otherwise the queue head starts at once
    assign w_src_bits  = r_busy ? r_shift : i_q_bits;
    assign w_src_rem   = r_busy ? r_rem : i_q_len;
    assign w_src_fe    = r_busy ? r_fe : i_q_ctl.frame_end;
    assign w_src_final = (w_src_rem == LEN_W'(1));

    assign w_advance = !r_out_valid || i_ready;
    assign w_emit    = w_advance && (r_busy || i_q_valid);
    assign o_q_pop   = w_advance && !r_busy && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_shift               <= w_src_bits >> 1;
            r_rem                 <= w_src_rem - LEN_W'(1);
            r_fe                  <= w_src_fe;
            r_out_bit             <= w_src_bits[0];
            r_out_ctl.frame_start <= !r_busy && i_q_ctl.frame_start;
            r_out_ctl.frame_end   <= w_src_fe && w_src_final;
            r_out_last            <= w_src_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_busy <= !w_src_final;
            end
            if (w_advance) begin
                r_out_valid <= w_emit;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_bit = r_out_bit;
    assign o_ctl      = r_out_ctl;
    assign o_last     = r_out_last;

endmodule

/* rtl/lcd_controller_frame_serializer.sv */
// top level of the three-wire lcd frame serializer
// path: an item that is taken is written into the queue, and its first wire bit then passes the output register
// throughput: one wire bit per cycle from the output shift register while the wire side is ready; an item is
//   ID_BITS + CMD_BITS bits for a command, 3 + ADDRESS_BITS + DATA_BITS for a write
//   that opens a frame and DATA_BITS for a continuing write (12, 13 and 4 by default)
// reset: synchronous active low, clears the queue, the open-frame flag, the busy flag and out valid
`timescale 1ns / 1ps

module lcd_controller_frame_serializer
    import lcdfs_pkg::*;
#(
    parameter int ADDRESS_BITS = 6,
    parameter int DATA_BITS    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request side
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // command_byte, address, nibble, zero pad
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // operation, first_nibble
    input  logic                 i_s_tlast,  // last_nibble
    // wire bit side
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // data_bit, zero pad
    output logic [M_TUSER_W-1:0] o_m_tuser,  // frame_start, frame_end
    output logic                 o_m_tlast   // last bit of the item
);

    // longest run on the wire, command frame or opening write
    localparam int WR_LEN     = ID_BITS + ADDRESS_BITS + DATA_BITS;
    localparam int CMD_LEN    = ID_BITS + CMD_BITS;
    localparam int FRAME_BITS = (WR_LEN > CMD_LEN) ? WR_LEN : CMD_LEN;
    localparam int LEN_W      = $clog2(FRAME_BITS + 1);
    localparam int CTL_W      = $bits(t_frame_ctl);
    localparam int Q_W        = FRAME_BITS + LEN_W + CTL_W;

    // request field positions
    localparam int CMD_LSB  = 0;
    localparam int ADDR_LSB = CMD_LSB + CMD_W;
    localparam int NIB_LSB  = ADDR_LSB + ADDR_W;

    logic                  w_front_valid;
    logic                  w_accept;
    logic [FRAME_BITS-1:0] w_front_bits;
    logic [LEN_W-1:0]      w_front_len;
    t_frame_ctl            w_front_ctl;

    logic                  w_q_full;
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic [Q_W-1:0]        w_q_data;
    logic [FRAME_BITS-1:0] w_q_bits;
    logic [LEN_W-1:0]      w_q_len;
    t_frame_ctl            w_q_ctl;

    logic                  w_out_bit;
    t_frame_ctl            w_out_ctl;

    // an item is taken whenever the queue has room
    assign o_s_tready = !w_q_full;
    assign w_accept   = w_front_valid && !w_q_full;

    lcdfs_front #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS),
        .FRAME_BITS   (FRAME_BITS),
        .LEN_W        (LEN_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .i_accept       (w_accept),
        .i_op           (t_op'(i_s_tuser[0])),
        .i_command_byte (i_s_tdata[CMD_LSB +: CMD_W]),
        .i_address      (i_s_tdata[ADDR_LSB +: ADDR_W]),
        .i_nibble       (i_s_tdata[NIB_LSB +: NIB_W]),
        .i_first_nibble (i_s_tuser[1]),
        .i_last_nibble  (i_s_tlast),
        .o_valid        (w_front_valid),
        .o_bits         (w_front_bits),
        .o_len          (w_front_len),
        .o_ctl          (w_front_ctl)
    );

    // short queue so front and back stall independently
    lcdfs_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  ({w_front_bits, w_front_len, w_front_ctl}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign {w_q_bits, w_q_len, w_q_ctl} = w_q_data;

    lcdfs_back #(
        .FRAME_BITS (FRAME_BITS),
        .LEN_W      (LEN_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_bits   (w_q_bits),
        .i_q_len    (w_q_len),
        .i_q_ctl    (w_q_ctl),
        .o_q_pop    (w_q_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data_bit (w_out_bit),
        .o_ctl      (w_out_ctl),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = M_TDATA_W'(w_out_bit);
    assign o_m_tuser = {w_out_ctl.frame_end, w_out_ctl.frame_start};

endmodule

/* rtl/lcdfs_checker.sv */
// port-level checks of the lcd frame serializer, bound to the top level
`timescale 1ns / 1ps

module lcdfs_checker
    import lcdfs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [M_TUSER_W-1:0] o_m_tuser,
    input logic                 o_m_tlast
);

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a stalled wire bit keeps its value and flags
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled output changed");

    // a frame only closes on the final bit of an item
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast)
        else $error("frame end on a bit that is not the last of its item");

    // no frame is one bit long
    a_start_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("frame start and frame end on the same bit");

    // a frame start bit is always the high id bit
    a_start_bit_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[0])
        else $error("frame start bit is not a one");

endmodule

bind lcd_controller_frame_serializer lcdfs_checker u_lcdfs_checker (.*);
